// File: rtl/core/fbsc_pkg.sv
// Shared types, constants and helpers for the boot sector classifier.
package fbsc_pkg;

  // Bytes of one boot sector; bytes past this count are dropped
  localparam int SectorBytes = 512;
  localparam int PosW        = 10;

  // Snapshot queue depth between the capture side and the evaluation side
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  // Soft and hard test constants
  localparam logic [7:0]  JumpShort   = 8'hEB;
  localparam logic [7:0]  JumpNop     = 8'h90;
  localparam logic [7:0]  JumpNear    = 8'hE9;
  localparam logic [7:0]  MediaFixed  = 8'hF0;
  localparam logic [7:0]  MediaLowest = 8'hF8;
  localparam logic [15:0] BootSig     = 16'h55AA;
  localparam logic [15:0] AtariSum    = 16'h1234;
  localparam logic [63:0] Fat12Limit  = 64'd4085;
  localparam logic [63:0] Fat16Limit  = 64'd65525;

  typedef enum logic [2:0] {
    OUT_ACCEPTED         = 3'd0,
    OUT_SHORT            = 3'd1,
    OUT_BAD_SECTOR_SIZE  = 3'd2,
    OUT_BAD_CLUSTER_SIZE = 3'd3,
    OUT_FOREIGN_TAG      = 3'd4
  } outcome_e;

  typedef enum logic [1:0] {
    KIND_FAT12 = 2'd0,
    KIND_FAT16 = 2'd1,
    KIND_FAT32 = 2'd2
  } fat_kind_e;

  // Parameter block fields captured from one sector
  typedef struct packed {
    logic [15:0] word_sum;
    logic [7:0]  jump_first;
    logic [7:0]  jump_third;
    logic [15:0] sector_size;
    logic [7:0]  cluster_size;
    logic        tag_match;
    logic [15:0] reserved_sectors;
    logic [7:0]  fat_copies;
    logic [15:0] root_entries;
    logic [15:0] short_total;
    logic [7:0]  media_byte;
    logic [15:0] short_fat_size;
    logic [31:0] long_total;
    logic [31:0] long_fat_size;
    logic [15:0] signature;
  } sector_fields_t;

  // Capture state after reset and at the start of each sector
  localparam sector_fields_t FieldsInit = '{tag_match: 1'b1, default: '0};

  // One finished sector: captured fields plus the full-length flag
  typedef struct packed {
    logic           full;
    sector_fields_t fields;
  } sector_snap_t;

  // Foreign volume tag expected at offsets 3..10
  function automatic logic [7:0] tag_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h4E;
      3'd1:    val = 8'h54;
      3'd2:    val = 8'h46;
      3'd3:    val = 8'h53;
      default: val = 8'h20;
    endcase
    return val;
  endfunction

endpackage

// File: rtl/core/fbsc_front.sv
// Capture side: absorbs sector bytes and emits a field snapshot per sector.
module fbsc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  beat_i,
  input  logic [7:0]            sector_byte_i,
  input  logic                  sector_end_i,
  output logic                  push_o,
  output fbsc_pkg::sector_snap_t snap_o
);
  import fbsc_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  sector_fields_t  fields_q, fields_d;
  logic [2:0]      tag_idx;
  logic            absorb;

  assign absorb  = (pos_q < PosW'(SectorBytes));
  assign tag_idx = 3'(pos_q - PosW'(3));

  // Fold the current byte into the captured fields
  always_comb begin
    fields_d = fields_q;
    pos_d    = pos_q;
    if (absorb) begin
      if (pos_q[0]) begin
        fields_d.word_sum = fields_q.word_sum + {8'h00, sector_byte_i};
      end else begin
        fields_d.word_sum = fields_q.word_sum + {sector_byte_i, 8'h00};
      end
      if ((pos_q >= PosW'(3)) && (pos_q <= PosW'(10)) &&
          (sector_byte_i != tag_byte(tag_idx))) begin
        fields_d.tag_match = 1'b0;
      end
      case (pos_q)
        10'd0:   fields_d.jump_first             = sector_byte_i;
        10'd2:   fields_d.jump_third             = sector_byte_i;
        10'd11:  fields_d.sector_size[7:0]       = sector_byte_i;
        10'd12:  fields_d.sector_size[15:8]      = sector_byte_i;
        10'd13:  fields_d.cluster_size           = sector_byte_i;
        10'd14:  fields_d.reserved_sectors[7:0]  = sector_byte_i;
        10'd15:  fields_d.reserved_sectors[15:8] = sector_byte_i;
        10'd16:  fields_d.fat_copies             = sector_byte_i;
        10'd17:  fields_d.root_entries[7:0]      = sector_byte_i;
        10'd18:  fields_d.root_entries[15:8]     = sector_byte_i;
        10'd19:  fields_d.short_total[7:0]       = sector_byte_i;
        10'd20:  fields_d.short_total[15:8]      = sector_byte_i;
        10'd21:  fields_d.media_byte             = sector_byte_i;
        10'd22:  fields_d.short_fat_size[7:0]    = sector_byte_i;
        10'd23:  fields_d.short_fat_size[15:8]   = sector_byte_i;
        10'd32:  fields_d.long_total[7:0]        = sector_byte_i;
        10'd33:  fields_d.long_total[15:8]       = sector_byte_i;
        10'd34:  fields_d.long_total[23:16]      = sector_byte_i;
        10'd35:  fields_d.long_total[31:24]      = sector_byte_i;
        10'd36:  fields_d.long_fat_size[7:0]     = sector_byte_i;
        10'd37:  fields_d.long_fat_size[15:8]    = sector_byte_i;
        10'd38:  fields_d.long_fat_size[23:16]   = sector_byte_i;
        10'd39:  fields_d.long_fat_size[31:24]   = sector_byte_i;
        10'd510: fields_d.signature[15:8]        = sector_byte_i;
        10'd511: fields_d.signature[7:0]         = sector_byte_i;
        default: ;
      endcase
      pos_d = pos_q + PosW'(1);
    end
  end

  // Hand the finished sector to the queue on its last beat
  assign push_o        = beat_i && sector_end_i;
  assign snap_o.full   = (pos_d >= PosW'(SectorBytes));
  assign snap_o.fields = fields_d;

  // Advance on each beat, restart after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      fields_q <= FieldsInit;
    end else if (beat_i) begin
      if (sector_end_i) begin
        pos_q    <= '0;
        fields_q <= FieldsInit;
      end else begin
        pos_q    <= pos_d;
        fields_q <= fields_d;
      end
    end
  end

endmodule

// File: rtl/core/fbsc_queue.sv
// Short snapshot queue that decouples capture from evaluation.
module fbsc_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  fbsc_pkg::sector_snap_t push_data_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   valid_o,
  output fbsc_pkg::sector_snap_t data_o
);
  import fbsc_pkg::*;

  sector_snap_t         entries_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   count_q;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == (QueuePtrW + 1)'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign data_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store the incoming snapshot
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QueuePtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (QueuePtrW + 1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (QueuePtrW + 1)'(1);
      end
    end
  end

endmodule

// File: rtl/core/fbsc_back.sv
// Evaluation side: three-stage pipeline from snapshot to result beat.
module fbsc_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   snap_valid_i,
  input  fbsc_pkg::sector_snap_t snap_i,
  output logic                   snap_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [2:0]             outcome_o,
  output logic [1:0]             fat_kind_o,
  output logic [2:0]             hint_score_o,
  output logic                   atari_bootable_o,
  output logic [63:0]            cluster_count_o,
  output logic [12:0]            bytes_per_sector_o,
  output logic [7:0]             sectors_per_cluster_o
);
  import fbsc_pkg::*;

  typedef struct packed {
    outcome_e    outcome;
    logic [2:0]  score;
    logic        atari;
    logic [31:0] total;
    logic [15:0] reserved;
    logic [31:0] fat_sectors;
    logic [12:0] dir_sectors;
    logic [2:0]  cs_shift;
    logic [12:0] bps;
    logic [7:0]  spc;
  } a_stage_t;

  typedef struct packed {
    outcome_e    outcome;
    logic [2:0]  score;
    logic        atari;
    logic [32:0] diff;
    logic [2:0]  cs_shift;
    logic [12:0] bps;
    logic [7:0]  spc;
  } b_stage_t;

  sector_fields_t f;
  a_stage_t       a_d, a_q;
  b_stage_t       b_d, b_q;
  logic           a_valid_q, b_valid_q, o_valid_q;
  logic           a_en, b_en, o_en;
  logic           ss_ok, cs_ok, jump_ok, media_ok, rsv_ok;
  logic [31:0]    total, fsize;
  logic [31:0]    prod;
  logic [21:0]    dir_num;
  logic [31:0]    used;
  logic [63:0]    clusters;

  assign f = snap_i.fields;

  // Stall chain: a stage advances when the one after it frees up
  assign o_en       = !o_valid_q || out_ready_i;
  assign b_en       = !b_valid_q || o_en;
  assign a_en       = !a_valid_q || b_en;
  assign snap_pop_o = a_en && snap_valid_i;

  // Stage A: hard tests, soft tests, table size product
  assign ss_ok = (f.sector_size == 16'd512) || (f.sector_size == 16'd1024) ||
                 (f.sector_size == 16'd2048) || (f.sector_size == 16'd4096);
  assign cs_ok = (f.cluster_size != 8'd0) &&
                 ((f.cluster_size & (f.cluster_size - 8'd1)) == 8'd0);
  assign jump_ok  = ((f.jump_first == JumpShort) && (f.jump_third == JumpNop)) ||
                    (f.jump_first == JumpNear);
  assign media_ok = (f.media_byte == MediaFixed) || (f.media_byte >= MediaLowest);
  assign rsv_ok   = (f.reserved_sectors == 16'd1) || (f.reserved_sectors == 16'd32);
  assign total    = (f.short_total != 16'd0) ? {16'h0000, f.short_total} : f.long_total;
  assign fsize    = (f.short_fat_size != 16'd0) ? {16'h0000, f.short_fat_size}
                                                : f.long_fat_size;
  assign prod     = {24'h000000, f.fat_copies} * fsize;
  assign dir_num  = {1'b0, f.root_entries, 5'b00000} + {10'd0, 12'(f.sector_size - 16'd1)};

  always_comb begin
    a_d = '0;
    if (!snap_i.full) begin
      a_d.outcome = OUT_SHORT;
    end else if (!ss_ok) begin
      a_d.outcome = OUT_BAD_SECTOR_SIZE;
    end else if (!cs_ok) begin
      a_d.outcome = OUT_BAD_CLUSTER_SIZE;
    end else if (f.tag_match) begin
      a_d.outcome = OUT_FOREIGN_TAG;
    end else begin
      a_d.outcome = OUT_ACCEPTED;
    end
    a_d.score = {2'b00, jump_ok} + {2'b00, (f.signature == BootSig)} + {2'b00, rsv_ok} +
                {2'b00, (f.fat_copies == 8'd2)} + {2'b00, media_ok};
    a_d.atari       = (f.word_sum == AtariSum);
    a_d.total       = total;
    a_d.reserved    = f.reserved_sectors;
    a_d.fat_sectors = prod;
    // Root directory sectors: round up, divide by the sector size
    case (f.sector_size)
      16'd512:  a_d.dir_sectors = 13'(dir_num >> 9);
      16'd1024: a_d.dir_sectors = 13'(dir_num >> 10);
      16'd2048: a_d.dir_sectors = 13'(dir_num >> 11);
      default:  a_d.dir_sectors = 13'(dir_num >> 12);
    endcase
    // Cluster size is a power of two here: take its exponent
    for (int i = 0; i < 8; i++) begin
      if (f.cluster_size[i]) begin
        a_d.cs_shift = 3'(i);
      end
    end
    a_d.bps = f.sector_size[12:0];
    a_d.spc = f.cluster_size;
  end

  // Stage B: sectors in use, then data sectors with 64-bit wrap
  assign used = {16'h0000, a_q.reserved} + a_q.fat_sectors + {19'd0, a_q.dir_sectors};

  always_comb begin
    b_d.outcome  = a_q.outcome;
    b_d.score    = a_q.score;
    b_d.atari    = a_q.atari;
    b_d.diff     = {1'b0, a_q.total} - {1'b0, used};
    b_d.cs_shift = a_q.cs_shift;
    b_d.bps      = a_q.bps;
    b_d.spc      = a_q.spc;
  end

  // Stage C: divide by cluster size and pick the table kind
  assign clusters = {{31{b_q.diff[32]}}, b_q.diff} >> b_q.cs_shift;

  // Pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (a_en) a_valid_q <= snap_valid_i;
      if (b_en) b_valid_q <= a_valid_q;
      if (o_en) o_valid_q <= b_valid_q;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (a_en && snap_valid_i) begin
      a_q <= a_d;
    end
    if (b_en && a_valid_q) begin
      b_q <= b_d;
    end
    if (o_en && b_valid_q) begin
      outcome_o             <= b_q.outcome;
      bytes_per_sector_o    <= b_q.bps;
      sectors_per_cluster_o <= b_q.spc;
      if (b_q.outcome == OUT_ACCEPTED) begin
        hint_score_o     <= b_q.score;
        atari_bootable_o <= b_q.atari;
        cluster_count_o  <= clusters;
        if (clusters < Fat12Limit) begin
          fat_kind_o <= KIND_FAT12;
        end else if (clusters < Fat16Limit) begin
          fat_kind_o <= KIND_FAT16;
        end else begin
          fat_kind_o <= KIND_FAT32;
        end
      end else begin
        hint_score_o     <= '0;
        atari_bootable_o <= 1'b0;
        cluster_count_o  <= '0;
        fat_kind_o       <= KIND_FAT12;
      end
    end
  end

  assign out_valid_o = o_valid_q;

endmodule

// File: rtl/core/fat_boot_sector_classifier_unit.sv
// Top level of the boot sector classifier: capture, queue and evaluation.
//
// Accepts one sector byte per cycle while the snapshot queue has room, with no
// gaps between sectors; a sector of any length, down to a single byte, may
// follow the previous one at once. On the beat that carries sector_end the
// captured parameter block fields are pushed into a two-entry snapshot queue
// and capture restarts for the next sector. The evaluation pipeline (tests and
// table-size multiply, used sectors and subtract, cluster-size shift and kind
// compare) registers each step and can deliver one result per cycle while
// results are taken downstream. in_ready_o drops only while the snapshot queue
// is full, which happens when results are not taken downstream. Bytes past
// offset 511 are dropped, but their end mark still closes the sector.
module fat_boot_sector_classifier_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  sector_byte_i,
  input  logic        sector_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  outcome_o,
  output logic [1:0]  fat_kind_o,
  output logic [2:0]  hint_score_o,
  output logic        atari_bootable_o,
  output logic [63:0] cluster_count_o,
  output logic [12:0] bytes_per_sector_o,
  output logic [7:0]  sectors_per_cluster_o
);
  import fbsc_pkg::*;

  sector_snap_t push_snap, head_snap;
  logic         push, q_full, q_valid, pop, beat;

  assign in_ready_o = !q_full;
  assign beat       = in_valid_i && in_ready_o;

  // Capture the sector fields byte by byte
  fbsc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .beat_i        (beat),
    .sector_byte_i (sector_byte_i),
    .sector_end_i  (sector_end_i),
    .push_o        (push),
    .snap_o        (push_snap)
  );

  // Buffer finished sectors
  fbsc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_snap),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (head_snap)
  );

  // Evaluate and deliver results
  fbsc_back u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .snap_valid_i          (q_valid),
    .snap_i                (head_snap),
    .snap_pop_o            (pop),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .outcome_o             (outcome_o),
    .fat_kind_o            (fat_kind_o),
    .hint_score_o          (hint_score_o),
    .atari_bootable_o      (atari_bootable_o),
    .cluster_count_o       (cluster_count_o),
    .bytes_per_sector_o    (bytes_per_sector_o),
    .sectors_per_cluster_o (sectors_per_cluster_o)
  );

endmodule

// File: rtl/core/fbsc_checker.sv
// Port-level checker for the boot sector classifier, bound to the top level.
module fbsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  outcome_o,
  input logic [1:0]  fat_kind_o,
  input logic [2:0]  hint_score_o,
  input logic        atari_bootable_o,
  input logic [63:0] cluster_count_o,
  input logic [12:0] bytes_per_sector_o,
  input logic [7:0]  sectors_per_cluster_o
);
  import fbsc_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(outcome_o) &&
      $stable(cluster_count_o) && $stable(hint_score_o))
    else $error("result beat changed while stalled");

  // Drop derived fields on a rejected sector
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o != OUT_ACCEPTED) |->
      (fat_kind_o == KIND_FAT12) && (hint_score_o == 3'd0) &&
      !atari_bootable_o && (cluster_count_o == 64'd0))
    else $error("rejected sector carries derived fields");

  // Accepted sector passed the size tests
  a_accept_sizes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o == OUT_ACCEPTED) |->
      ((bytes_per_sector_o == 13'd512) || (bytes_per_sector_o == 13'd1024) ||
       (bytes_per_sector_o == 13'd2048) || (bytes_per_sector_o == 13'd4096)) &&
      $onehot(sectors_per_cluster_o))
    else $error("accepted sector with bad sizes");

  // Table kind agrees with the cluster count
  a_kind_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o == OUT_ACCEPTED) |->
      ((fat_kind_o == KIND_FAT12) && (cluster_count_o < Fat12Limit)) ||
      ((fat_kind_o == KIND_FAT16) && (cluster_count_o >= Fat12Limit) &&
       (cluster_count_o < Fat16Limit)) ||
      ((fat_kind_o == KIND_FAT32) && (cluster_count_o >= Fat16Limit)))
    else $error("table kind does not match cluster count");

  // Keep codes in range
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (outcome_o <= OUT_FOREIGN_TAG) && (hint_score_o <= 3'd5))
    else $error("outcome or hint score out of range");

endmodule

bind fat_boot_sector_classifier_unit fbsc_checker u_fbsc_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .out_valid_o           (out_valid_o),
  .out_ready_i           (out_ready_i),
  .outcome_o             (outcome_o),
  .fat_kind_o            (fat_kind_o),
  .hint_score_o          (hint_score_o),
  .atari_bootable_o      (atari_bootable_o),
  .cluster_count_o       (cluster_count_o),
  .bytes_per_sector_o    (bytes_per_sector_o),
  .sectors_per_cluster_o (sectors_per_cluster_o)
);

// File: sim/tb_fat_boot_sector_classifier_unit.sv
// Self-checking testbench for the boot sector classifier unit.
`timescale 1ns / 100ps

module tb_fat_boot_sector_classifier_unit;
  import fbsc_pkg::*;

  // Foreign volume tag at offsets 3..10, first byte in the top bits
  localparam logic [63:0] ForeignTag = 64'h4E54_4653_2020_2020;
  localparam int HoldOff = 300;

  // One result beat as the block should report it
  typedef struct packed {
    outcome_e    outcome;
    fat_kind_e   kind;
    logic [2:0]  hint;
    logic        atari;
    logic [63:0] clusters;
    logic [12:0] bps;
    logic [7:0]  spc;
  } verdict_t;

  // Layout of one sector to send; tag: 0 none, 1 full, 2 one byte off
  typedef struct {
    int          len;
    logic [7:0]  j0, j2;
    logic [15:0] ss;
    logic [7:0]  cs;
    logic [1:0]  tag;
    logic [15:0] rsv;
    logic [7:0]  copies;
    logic [15:0] root, stot;
    logic [7:0]  media;
    logic [15:0] sfat;
    logic [31:0] ltot, lfat;
    logic [15:0] sig;
    bit          atari;
    bit          typed;
    outcome_e    want;
  } sector_plan_t;

  typedef logic [7:0] byte_q_t [$];

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  logic [7:0]  sector_byte = 8'h00;
  logic        sector_end = 1'b0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [2:0]  outcome_o;
  logic [1:0]  fat_kind_o;
  logic [2:0]  hint_score_o;
  logic        atari_bootable_o;
  logic [63:0] cluster_count_o;
  logic [12:0] bytes_per_sector_o;
  logic [7:0]  sectors_per_cluster_o;

  // Predictor state: fields captured so far and the byte offset
  sector_fields_t acc;
  logic [9:0]     acc_pos;

  verdict_t     verdict_q [$];
  sector_plan_t plan_q [$];
  sector_plan_t dir_plan [16];

  bit steady   = 1'b0;
  bit hold_req = 1'b0;
  int fails = 0;
  int results_seen = 0;
  int accepted = 0;
  int sectors_sent = 0;
  int bytes_sent = 0;
  int stall_cycles = 0;

  always #5 clk = ~clk;

  fat_boot_sector_classifier_unit uut (
    .clk_i                 (clk),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid),
    .in_ready_o            (in_ready_o),
    .sector_byte_i         (sector_byte),
    .sector_end_i          (sector_end),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready),
    .outcome_o             (outcome_o),
    .fat_kind_o            (fat_kind_o),
    .hint_score_o          (hint_score_o),
    .atari_bootable_o      (atari_bootable_o),
    .cluster_count_o       (cluster_count_o),
    .bytes_per_sector_o    (bytes_per_sector_o),
    .sectors_per_cluster_o (sectors_per_cluster_o)
  );

  function automatic void clear_capture();
    acc = '0;
    acc.tag_match = 1'b1;
    acc_pos = '0;
  endfunction

  // Absorb one byte; on the end mark, fill in the verdict and return 1
  function automatic bit classify_byte(input logic [7:0] b, input logic last,
                                       output verdict_t v);
    int          p;
    int          sc;
    logic [15:0] ss;
    logic [7:0]  cs;
    logic [63:0] total, diff;
    logic [31:0] fsize, dirsecs, used;
    v = '0;
    if (acc_pos < SectorBytes) begin
      p = acc_pos;
      acc.word_sum = acc.word_sum + (p[0] ? {8'h00, b} : {b, 8'h00});
      if (p >= 3 && p <= 10 && b != ForeignTag[8*(10-p) +: 8]) acc.tag_match = 1'b0;
      case (p)
        0:              acc.jump_first = b;
        2:              acc.jump_third = b;
        11, 12:         acc.sector_size[8*(p-11) +: 8] = b;
        13:             acc.cluster_size = b;
        14, 15:         acc.reserved_sectors[8*(p-14) +: 8] = b;
        16:             acc.fat_copies = b;
        17, 18:         acc.root_entries[8*(p-17) +: 8] = b;
        19, 20:         acc.short_total[8*(p-19) +: 8] = b;
        21:             acc.media_byte = b;
        22, 23:         acc.short_fat_size[8*(p-22) +: 8] = b;
        32, 33, 34, 35: acc.long_total[8*(p-32) +: 8] = b;
        36, 37, 38, 39: acc.long_fat_size[8*(p-36) +: 8] = b;
        510:            acc.signature[15:8] = b;
        511:            acc.signature[7:0] = b;
        default: ;
      endcase
      acc_pos = acc_pos + 10'd1;
    end
    if (!last) return 1'b0;

    ss = acc.sector_size;
    cs = acc.cluster_size;
    // Hard tests in priority order
    if (acc_pos < SectorBytes) v.outcome = OUT_SHORT;
    else if (ss != 16'd512 && ss != 16'd1024 && ss != 16'd2048 && ss != 16'd4096)
      v.outcome = OUT_BAD_SECTOR_SIZE;
    else if (cs == 8'd0 || (cs & (cs - 8'd1)) != 8'd0) v.outcome = OUT_BAD_CLUSTER_SIZE;
    else if (acc.tag_match) v.outcome = OUT_FOREIGN_TAG;
    else v.outcome = OUT_ACCEPTED;

    if (v.outcome == OUT_ACCEPTED) begin
      sc = 0;
      if ((acc.jump_first == JumpShort && acc.jump_third == JumpNop) ||
          acc.jump_first == JumpNear) sc++;
      if (acc.signature == BootSig) sc++;
      if (acc.reserved_sectors == 16'd1 || acc.reserved_sectors == 16'd32) sc++;
      if (acc.fat_copies == 8'd2) sc++;
      if (acc.media_byte == MediaFixed || acc.media_byte >= MediaLowest) sc++;
      v.hint = 3'(sc);

      // Data area: sectors left after reserved, tables and root directory
      total = (acc.short_total != 16'd0) ? 64'(acc.short_total) : 64'(acc.long_total);
      fsize = (acc.short_fat_size != 16'd0) ? 32'(acc.short_fat_size) : acc.long_fat_size;
      dirsecs = (32'(acc.root_entries) * 32'd32 + 32'(ss) - 32'd1) / 32'(ss);
      used = 32'(acc.reserved_sectors) + 32'(acc.fat_copies) * fsize + dirsecs;
      diff = total - 64'(used);
      v.clusters = diff / 64'(cs);
      if (v.clusters < Fat12Limit) v.kind = KIND_FAT12;
      else if (v.clusters < Fat16Limit) v.kind = KIND_FAT16;
      else v.kind = KIND_FAT32;
      v.atari = (acc.word_sum == AtariSum);
    end
    v.bps = ss[12:0];
    v.spc = cs;
    clear_capture();
    return 1'b1;
  endfunction

  // Expand a layout into the byte stream of one sector
  function automatic byte_q_t lay_out(input sector_plan_t sp);
    logic [7:0]  raw [SectorBytes];
    byte_q_t     img;
    logic [15:0] sum;
    foreach (raw[i]) raw[i] = 8'($urandom);
    raw[0] = sp.j0;
    raw[2] = sp.j2;
    {raw[12], raw[11]} = sp.ss;
    raw[13] = sp.cs;
    {raw[15], raw[14]} = sp.rsv;
    raw[16] = sp.copies;
    {raw[18], raw[17]} = sp.root;
    {raw[20], raw[19]} = sp.stot;
    raw[21] = sp.media;
    {raw[23], raw[22]} = sp.sfat;
    {raw[35], raw[34], raw[33], raw[32]} = sp.ltot;
    {raw[39], raw[38], raw[37], raw[36]} = sp.lfat;
    {raw[510], raw[511]} = sp.sig;
    if (sp.tag != 2'd0)
      for (int k = 0; k < 8; k++) raw[3+k] = ForeignTag[63-8*k -: 8];
    // Near miss: spoil one tag byte
    if (sp.tag == 2'd2) raw[3 + $urandom_range(0, 7)] ^= 8'h01;
    // Patch the word at 508 so the big-endian sum hits the checksum value
    if (sp.atari) begin
      sum = '0;
      for (int w = 0; w < 256; w++)
        if (w != 254) sum += {raw[2*w], raw[2*w+1]};
      {raw[508], raw[509]} = AtariSum - sum;
    end
    for (int i = 0; i < sp.len; i++)
      img.push_back(i < SectorBytes ? raw[i] : 8'($urandom));
    return img;
  endfunction

  // Mostly well-formed layouts with random content, some broken ones
  function automatic sector_plan_t random_plan();
    sector_plan_t sp;
    int r;
    r = $urandom_range(0, 99);
    sp.len = (r < 62) ? 512 : (r < 72) ? $urandom_range(513, 560) :
             (r < 92) ? $urandom_range(1, 40) : $urandom_range(41, 511);
    case ($urandom_range(0, 3))
      0: begin sp.j0 = JumpShort; sp.j2 = JumpNop; end
      1: begin sp.j0 = JumpShort; sp.j2 = 8'($urandom); end
      2: begin sp.j0 = JumpNear; sp.j2 = 8'($urandom); end
      default: begin sp.j0 = 8'($urandom); sp.j2 = 8'($urandom); end
    endcase
    sp.ss = ($urandom_range(0, 99) < 85) ? 16'd512 << $urandom_range(0, 3) : 16'($urandom);
    sp.cs = ($urandom_range(0, 99) < 85) ? 8'd1 << $urandom_range(0, 7) : 8'($urandom);
    r = $urandom_range(0, 99);
    sp.tag = (r < 4) ? 2'd1 : (r < 8) ? 2'd2 : 2'd0;
    case ($urandom_range(0, 3))
      0: sp.rsv = 16'd1;
      1: sp.rsv = 16'd32;
      2: sp.rsv = 16'($urandom_range(0, 64));
      default: sp.rsv = 16'($urandom);
    endcase
    r = $urandom_range(0, 99);
    sp.copies = (r < 60) ? 8'd2 : (r < 80) ? 8'd1 : 8'($urandom);
    case ($urandom_range(0, 3))
      0: sp.root = 16'd0;
      1: sp.root = 16'd224;
      2: sp.root = 16'd512;
      default: sp.root = 16'($urandom);
    endcase
    sp.stot = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
    case ($urandom_range(0, 2))
      0: sp.media = MediaFixed;
      1: sp.media = 8'($urandom_range(8'hF8, 8'hFF));
      default: sp.media = 8'($urandom);
    endcase
    case ($urandom_range(0, 2))
      0: sp.sfat = 16'd0;
      1: sp.sfat = 16'($urandom_range(1, 300));
      default: sp.sfat = 16'($urandom);
    endcase
    sp.ltot = $urandom_range(0, 1) ? 32'($urandom_range(0, 100000)) : $urandom;
    sp.lfat = $urandom_range(0, 1) ? 32'($urandom_range(0, 20000)) : $urandom;
    sp.sig = ($urandom_range(0, 99) < 75) ? BootSig : 16'($urandom);
    sp.atari = ($urandom_range(0, 4) == 0);
    sp.typed = 1'b0;
    sp.want = OUT_ACCEPTED;
    return sp;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int sender_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 78) return 0;
    if (r < 97) return $urandom_range(1, 3);
    return $urandom_range(15, 40);
  endfunction

  // Offer one beat and hold it until accepted
  task automatic send_beat(input logic [7:0] b, input logic e, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    sector_byte <= b;
    sector_end  <= e;
    do @(posedge clk); while (!in_ready_o);
  endtask

  task automatic run_sector(input sector_plan_t sp);
    byte_q_t img;
    img = lay_out(sp);
    plan_q.push_back(sp);
    foreach (img[i]) send_beat(img[i], i == img.size() - 1, sender_gap());
    sectors_sent++;
    bytes_sent += sp.len;
  endtask

  // Drop valid and wait until every pending result has come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (verdict_q.size() != 0 || plan_q.size() != 0);
  endtask

  // Input side: run the predictor on every accepted beat
  always @(posedge clk) begin : watch_in
    verdict_t     v;
    sector_plan_t sp;
    bit           got;
    if (rst_ni && in_valid && !in_ready_o) stall_cycles++;
    if (rst_ni && in_valid && in_ready_o) begin
      got = classify_byte(sector_byte, sector_end, v);
      if (got) begin
        sp = plan_q.pop_front();
        // Rows with a hand-written outcome replace the prediction
        if (sp.typed) begin
          v = '0;
          v.outcome = sp.want;
          v.bps = (sp.len > 13) ? sp.ss[12:0] : 13'd0;
          v.spc = (sp.len > 13) ? sp.cs : 8'd0;
        end
        if (v.outcome == OUT_ACCEPTED) accepted++;
        verdict_q.push_back(v);
      end
    end
  end

  // Output side: compare each result beat with the oldest expectation
  always @(posedge clk) begin : watch_out
    verdict_t w;
    if (rst_ni && out_valid_o && out_ready) begin
      if (verdict_q.size() == 0) begin
        $error("result beat with nothing expected: outcome %0d", outcome_o);
        fails++;
      end else begin
        w = verdict_q.pop_front();
        results_seen++;
        if (outcome_o !== w.outcome) begin
          $error("outcome: expected %0d, got %0d", w.outcome, outcome_o);
          fails++;
        end
        if (fat_kind_o !== w.kind) begin
          $error("fat_kind: expected %0d, got %0d", w.kind, fat_kind_o);
          fails++;
        end
        if (hint_score_o !== w.hint) begin
          $error("hint_score: expected %0d, got %0d", w.hint, hint_score_o);
          fails++;
        end
        if (atari_bootable_o !== w.atari) begin
          $error("atari_bootable: expected %0d, got %0d", w.atari, atari_bootable_o);
          fails++;
        end
        if (cluster_count_o !== w.clusters) begin
          $error("cluster_count: expected %0h, got %0h", w.clusters, cluster_count_o);
          fails++;
        end
        if (bytes_per_sector_o !== w.bps) begin
          $error("bytes_per_sector: expected %0d, got %0d", w.bps, bytes_per_sector_o);
          fails++;
        end
        if (sectors_per_cluster_o !== w.spc) begin
          $error("sectors_per_cluster: expected %0d, got %0d", w.spc, sectors_per_cluster_o);
          fails++;
        end
      end
    end
  end

  // Receiver: random stalls, a long hold-off on request, steady when asked
  initial begin : drive_ready
    int r;
    wait (rst_ni);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldOff) @(posedge clk);
      end else if (steady) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(1, 16)) @(posedge clk);
        end else if (r < 95) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat ($urandom_range(15, 40)) @(posedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    #50_000_000;
    $display("fat_boot_sector_classifier_unit test failed");
    $finish;
  end

  initial begin : stimulus
    sector_plan_t sp;
    int n;
    int rbytes;
    // len, jump, ss, cs, tag, rsv, copies, root, stot, media, sfat, ltot, lfat,
    // sig, atari, typed, outcome
    dir_plan = '{
      // single byte right after reset
      '{1, 8'hEB, 8'h90, 16'd512, 8'd8, 2'd0, 16'd1, 8'd2, 16'd224, 16'd2880, 8'hF0,
        16'd9, 32'd0, 32'd0, 16'h55AA, 1'b0, 1'b1, OUT_SHORT},
      // short, cut right after the cluster size
      '{14, 8'hEB, 8'h90, 16'd512, 8'd8, 2'd0, 16'd1, 8'd2, 16'd224, 16'd2880, 8'hF0,
        16'd9, 32'd0, 32'd0, 16'h55AA, 1'b0, 1'b1, OUT_SHORT},
      // one byte short of a full sector
      '{511, 8'hEB, 8'h90, 16'd512, 8'd8, 2'd0, 16'd1, 8'd2, 16'd224, 16'd2880, 8'hF0,
        16'd9, 32'd0, 32'd0, 16'h55AA, 1'b0, 1'b1, OUT_SHORT},
      // bad sector sizes: all ones, zero, 8192 (reads back as 0)
      '{512, 8'hEB, 8'h90, 16'hFFFF, 8'd8, 2'd0, 16'd1, 8'd2, 16'd224, 16'd2880, 8'hF0,
        16'd9, 32'd0, 32'd0, 16'h55AA, 1'b0, 1'b1, OUT_BAD_SECTOR_SIZE},
      '{512, 8'hEB, 8'h90, 16'd0, 8'd8, 2'd0, 16'd1, 8'd2, 16'd224, 16'd2880, 8'hF0,
        16'd9, 32'd0, 32'd0, 16'h55AA, 1'b0, 1'b1, OUT_BAD_SECTOR_SIZE},
      '{512, 8'hEB, 8'h90, 16'h2000, 8'd8, 2'd0, 16'd1, 8'd2, 16'd224, 16'd2880, 8'hF0,
        16'd9, 32'd0, 32'd0, 16'h55AA, 1'b0, 1'b1, OUT_BAD_SECTOR_SIZE},
      // bad cluster sizes: zero, all ones
      '{512, 8'hEB, 8'h90, 16'd512, 8'd0, 2'd0, 16'd1, 8'd2, 16'd224, 16'd2880, 8'hF0,
        16'd9, 32'd0, 32'd0, 16'h55AA, 1'b0, 1'b1, OUT_BAD_CLUSTER_SIZE},
      '{512, 8'hEB, 8'h90, 16'd4096, 8'd255, 2'd0, 16'd1, 8'd2, 16'd224, 16'd2880, 8'hF0,
        16'd9, 32'd0, 32'd0, 16'h55AA, 1'b0, 1'b1, OUT_BAD_CLUSTER_SIZE},
      // foreign volume tag
      '{512, 8'hEB, 8'h90, 16'd512, 8'd8, 2'd1, 16'd1, 8'd2, 16'd224, 16'd2880, 8'hF0,
        16'd9, 32'd0, 32'd0, 16'h55AA, 1'b0, 1'b1, OUT_FOREIGN_TAG},
      // overlong sector, trailing bytes dropped
      '{600, 8'hEB, 8'h90, 16'd1024, 8'd3, 2'd0, 16'd1, 8'd2, 16'd224, 16'd2880, 8'hF0,
        16'd9, 32'd0, 32'd0, 16'h55AA, 1'b0, 1'b1, OUT_BAD_CLUSTER_SIZE},
      // floppy-like small volume
      '{512, 8'hEB, 8'h90, 16'd512, 8'd1, 2'd0, 16'd1, 8'd2, 16'd224, 16'd2880, 8'hF0,
        16'd9, 32'd0, 32'd0, 16'h55AA, 1'b0, 1'b0, OUT_ACCEPTED},
      // mid-size volume from the long total
      '{512, 8'hEB, 8'h90, 16'd512, 8'd4, 2'd0, 16'd1, 8'd2, 16'd512, 16'd0, 8'hF8,
        16'd200, 32'd200000, 32'd0, 16'h55AA, 1'b0, 1'b0, OUT_ACCEPTED},
      // long fields at their maximum
      '{512, 8'hEB, 8'h90, 16'd512, 8'd1, 2'd0, 16'd32, 8'd2, 16'd0, 16'd0, 8'hF8,
        16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h55AA, 1'b0, 1'b0, OUT_ACCEPTED},
      // used area larger than the volume, checksum forced
      '{512, 8'hE9, 8'h00, 16'd4096, 8'd128, 2'd0, 16'hFFFF, 8'hFF, 16'hFFFF, 16'd1, 8'h00,
        16'hFFFF, 32'd0, 32'd0, 16'hAA55, 1'b1, 1'b0, OUT_ACCEPTED},
      // all-zero fields, tag off by one byte
      '{512, 8'h00, 8'h90, 16'd2048, 8'd64, 2'd2, 16'd0, 8'd0, 16'd0, 16'd0, 8'hFF,
        16'd0, 32'd0, 32'd0, 16'h0000, 1'b1, 1'b0, OUT_ACCEPTED},
      // one byte past the sector, media just below the range
      '{513, 8'hEB, 8'h91, 16'd1024, 8'd2, 2'd0, 16'd32, 8'd1, 16'd16, 16'd0, 8'hF7,
        16'd0, 32'd70000, 32'd300, 16'h55AA, 1'b0, 1'b0, OUT_ACCEPTED}
    };
    clear_capture();
    repeat (5) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Directed sectors
    foreach (dir_plan[i]) run_sector(dir_plan[i]);
    settle();

    // A stretch with no idling on either side
    steady = 1'b1;
    repeat (6) run_sector(random_plan());
    steady = 1'b0;

    // Random sectors, with one back-pressure burst early on
    n = 0;
    rbytes = 0;
    while (rbytes < 1450) begin
      if (n == 2) begin
        settle();
        steady = 1'b1;
        hold_req = 1'b1;
        repeat (40) begin
          sp = random_plan();
          sp.len = $urandom_range(1, 6);
          run_sector(sp);
        end
        steady = 1'b0;
        settle();
      end
      sp = random_plan();
      run_sector(sp);
      rbytes += (sp.len < SectorBytes) ? sp.len : SectorBytes;
      n++;
    end

    settle();
    repeat (20) @(posedge clk);
    $display("Sent %0d sectors in %0d bytes; %0d results checked, %0d accepted sectors.",
             sectors_sent, bytes_sent, results_seen, accepted);
    $display("Input was held off for %0d cycles by output back-pressure.", stall_cycles);
    if (fails == 0 && verdict_q.size() == 0)
      $display("fat_boot_sector_classifier_unit test passed");
    else
      $display("fat_boot_sector_classifier_unit test failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/fbsc_pkg.sv
rtl/core/fbsc_front.sv
rtl/core/fbsc_queue.sv
rtl/core/fbsc_back.sv
rtl/core/fat_boot_sector_classifier_unit.sv
rtl/core/fbsc_checker.sv
sim/tb_fat_boot_sector_classifier_unit.sv
